[hw/rtl/sia_pkg.sv]
// Package for the signed integer ALU: command and status codes and the
// pipeline stage records. No dependencies.
package sia_pkg;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_REM = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  localparam int DIV_STAGES = 32;

  // First front stage: add/subtract done, raw product held.
  typedef struct packed {
    logic [2:0]  cmd;
    logic        a_neg;
    logic        b_neg;
    logic        divz;
    logic [31:0] abs_a;
    logic [31:0] abs_b;
    logic [31:0] arith_val;
    logic        arith_ovf;
    logic [63:0] product;
  } front_t;

  // Record carried through the divider stages.
  typedef struct packed {
    logic [2:0]  cmd;
    logic        a_neg;
    logic        b_neg;
    logic        divz;
    logic [31:0] val;
    logic        ovf;
    logic [31:0] part_rem;
    logic [31:0] quo;
    logic [31:0] divisor;
  } pipe_t;

endpackage

[hw/rtl/sia_if.sv]
// Request and result channel interfaces of the signed integer ALU.
// Standalone; no package needed.
interface sia_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, command, operand_a, operand_b, input ready);
  modport sink (input valid, command, operand_a, operand_b, output ready);
endinterface

interface sia_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic [1:0]  status;
  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

[hw/rtl/sia_front.sv]
// Front end of the signed integer ALU: operand decode, add/subtract and the
// multiplier, two register stages. Depends on sia_pkg.
module sia_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2:0]          command,
  input  logic signed [31:0]  operand_a,
  input  logic signed [31:0]  operand_b,
  output logic                valid_o,
  output sia_pkg::pipe_t      pipe_o
);

  sia_pkg::front_t f1_nxt, f1_r;
  sia_pkg::pipe_t  f2_nxt, f2_r;
  logic            v1_r, v2_r;
  logic [32:0]     sum_add, sum_sub;

  always_comb begin
    sum_add = {operand_a[31], operand_a} + {operand_b[31], operand_b};
    sum_sub = {operand_a[31], operand_a} - {operand_b[31], operand_b};
    f1_nxt.cmd   = command;
    f1_nxt.a_neg = operand_a[31];
    f1_nxt.b_neg = operand_b[31];
    f1_nxt.divz  = (operand_b == 32'sd0);
    f1_nxt.abs_a = operand_a[31] ? (32'd0 - operand_a) : operand_a;
    f1_nxt.abs_b = operand_b[31] ? (32'd0 - operand_b) : operand_b;
    f1_nxt.product = 64'(operand_a) * 64'(operand_b);
    if (command == sia_pkg::CMD_SUB) begin
      f1_nxt.arith_val = sum_sub[31:0];
      f1_nxt.arith_ovf = sum_sub[32] ^ sum_sub[31];
    end else begin
      f1_nxt.arith_val = sum_add[31:0];
      f1_nxt.arith_ovf = sum_add[32] ^ sum_add[31];
    end
  end

  always_comb begin
    f2_nxt.cmd      = f1_r.cmd;
    f2_nxt.a_neg    = f1_r.a_neg;
    f2_nxt.b_neg    = f1_r.b_neg;
    f2_nxt.divz     = f1_r.divz;
    f2_nxt.part_rem = '0;
    f2_nxt.quo      = f1_r.abs_a;
    f2_nxt.divisor  = f1_r.abs_b;
    unique case (f1_r.cmd)
      sia_pkg::CMD_ADD, sia_pkg::CMD_SUB: begin
        f2_nxt.val = f1_r.arith_val;
        f2_nxt.ovf = f1_r.arith_ovf;
      end
      sia_pkg::CMD_MUL: begin
        f2_nxt.val = f1_r.product[31:0];
        f2_nxt.ovf = !((&f1_r.product[63:31]) || !(|f1_r.product[63:31]));
      end
      default: begin
        f2_nxt.val = '0;
        f2_nxt.ovf = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
    end
  end

  assign valid_o = v2_r;
  assign pipe_o  = f2_r;

endmodule

[hw/rtl/sia_div_stage.sv]
// One restoring-division stage: produces one quotient bit per register.
// Depends on sia_pkg.
module sia_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           valid_i,
  input  sia_pkg::pipe_t pipe_i,
  output logic           valid_o,
  output sia_pkg::pipe_t pipe_o
);

  sia_pkg::pipe_t pipe_nxt, pipe_r;
  logic           valid_r;
  logic [32:0]    shifted;
  logic [33:0]    diff;

  always_comb begin
    shifted  = {pipe_i.part_rem, pipe_i.quo[31]};
    diff     = {1'b0, shifted} - {2'b00, pipe_i.divisor};
    pipe_nxt = pipe_i;
    if (!diff[33]) begin
      pipe_nxt.part_rem = diff[31:0];
      pipe_nxt.quo      = {pipe_i.quo[30:0], 1'b1};
    end else begin
      pipe_nxt.part_rem = shifted[31:0];
      pipe_nxt.quo      = {pipe_i.quo[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r <= pipe_nxt;
    end
  end

  assign valid_o = valid_r;
  assign pipe_o  = pipe_r;

endmodule

[hw/rtl/sia_back.sv]
// Back end of the signed integer ALU: sign fix-up of quotient and remainder,
// status selection and the output register. Depends on sia_pkg.
module sia_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  sia_pkg::pipe_t     pipe_i,
  output logic               valid_o,
  output logic signed [31:0] result_o,
  output logic [1:0]         status_o
);

  logic        valid_r;
  logic [31:0] res_nxt, res_r;
  logic [1:0]  st_nxt, st_r;
  logic        q_neg;

  always_comb begin
    q_neg = pipe_i.a_neg ^ pipe_i.b_neg;
    unique case (pipe_i.cmd)
      sia_pkg::CMD_ADD, sia_pkg::CMD_SUB, sia_pkg::CMD_MUL: begin
        res_nxt = pipe_i.val;
        st_nxt  = pipe_i.ovf ? sia_pkg::ST_OVF : sia_pkg::ST_OK;
      end
      sia_pkg::CMD_DIV: begin
        res_nxt = q_neg ? (32'd0 - pipe_i.quo) : pipe_i.quo;
        st_nxt  = (!q_neg && pipe_i.quo[31]) ? sia_pkg::ST_OVF : sia_pkg::ST_OK;
      end
      sia_pkg::CMD_REM: begin
        res_nxt = pipe_i.a_neg ? (32'd0 - pipe_i.part_rem) : pipe_i.part_rem;
        st_nxt  = sia_pkg::ST_OK;
      end
      default: begin
        res_nxt = '0;
        st_nxt  = sia_pkg::ST_OK;
      end
    endcase
    if ((pipe_i.cmd == sia_pkg::CMD_DIV || pipe_i.cmd == sia_pkg::CMD_REM) && pipe_i.divz) begin
      res_nxt = '0;
      st_nxt  = sia_pkg::ST_DIVZ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      st_r  <= st_nxt;
    end
  end

  assign valid_o  = valid_r;
  assign result_o = res_r;
  assign status_o = st_r;

endmodule

[hw/rtl/signed_integer_alu.sv]
// Top level of the signed integer ALU: front end, 32 divider stages, back end.
// Depends on sia_pkg, sia_if, sia_front, sia_div_stage and sia_back.
//
//   channel   direction   carries
//   in_ch     sink        command, operand_a, operand_b
//   out_ch    source      result_value, status
//
// Every request passes through 35 register stages: two front stages (operand
// decode, add/subtract, multiply and its overflow check), 32 restoring division
// stages of one quotient bit each, and the output register.
// A new request is taken every cycle while the result side keeps up.
// The whole pipeline advances together; when a finished result waits and the
// sink is not ready, every stage holds, so nothing is lost or repeated.
// Reset clears only the valid bits of the stages.
module signed_integer_alu (
  input  logic     clk,
  input  logic     rst_n,
  sia_in_if.sink   in_ch,
  sia_out_if.source out_ch
);

  // The pipeline moves whenever the output register is empty or being taken.
  logic advance;
  assign advance     = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = advance;

  // Valid bits and records between the stages; index 0 is the front end's output.
  logic           div_valid [sia_pkg::DIV_STAGES+1];
  sia_pkg::pipe_t div_pipe  [sia_pkg::DIV_STAGES+1];

  sia_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .in_valid  (in_ch.valid),
    .command   (in_ch.command),
    .operand_a (in_ch.operand_a),
    .operand_b (in_ch.operand_b),
    .valid_o   (div_valid[0]),
    .pipe_o    (div_pipe[0])
  );

  // One quotient bit per stage, most significant first.
  for (genvar gi = 0; gi < sia_pkg::DIV_STAGES; gi++) begin : g_div
    sia_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (advance),
      .valid_i (div_valid[gi]),
      .pipe_i  (div_pipe[gi]),
      .valid_o (div_valid[gi+1]),
      .pipe_o  (div_pipe[gi+1])
    );
  end

  sia_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .valid_i  (div_valid[sia_pkg::DIV_STAGES]),
    .pipe_i   (div_pipe[sia_pkg::DIV_STAGES]),
    .valid_o  (out_ch.valid),
    .result_o (out_ch.result_value),
    .status_o (out_ch.status)
  );

`ifndef SYNTH
  // A division-by-zero result always carries a zero value.
  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == sia_pkg::ST_DIVZ |-> out_ch.result_value == 32'sd0)
    else $error("divide by zero result is not zero");

  // The status never takes the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.status != 2'd3)
    else $error("unused status code");

  // While the result waits, no new request is taken.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("request accepted during stall");
`endif

endmodule
